// ===== rtl/swam_pkg.sv =====
// ----------------------------------------------------------------------------
// swam_pkg
// Shared constants and types of the sliding window anagram match block.
// ----------------------------------------------------------------------------
package swam_pkg;

    localparam int ALPHABET    = 26;
    localparam int LETTER_W    = 5;
    localparam int CNT_ADDR_W  = $clog2(ALPHABET);
    localparam int COUNT_W     = 11;
    localparam int DIFF_W      = $clog2(ALPHABET + 1);
    localparam int MAX_PATTERN = 1024;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_TEXT    = 1'b1;

    // One item on its way from the window control to the count update.
    typedef struct packed {
        logic                first;
        logic                add;
        logic                remove;
        logic                pat;
        logic                emit;
        logic                full;
        logic [LETTER_W-1:0] letter;
        logic [LETTER_W-1:0] old;
    } step_t;

    typedef struct packed {
        logic window_match;
        logic found;
        logic window_full;
    } result_t;

endpackage

// ===== rtl/sliding_window_anagram_match_top.sv =====
// ----------------------------------------------------------------------------
// sliding_window_anagram_match_top
// Streaming test of whether a window of text letters is a permutation of the
// pattern loaded before it.
// ----------------------------------------------------------------------------
// A text item's result passes through the step, update stage and output
// queue registers before it is offered. Throughput: one item per cycle while
// the result queue has room, set by the single read-modify-write pass through
// the two letter count memories and the ring memory.
// Reset clears all control state at once; count entries carry valid bits, so
// no clearing pass runs and the first item may enter right after reset.
module sliding_window_anagram_match_top
#(
    parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic                          first,
    input  logic [swam_pkg::LETTER_W-1:0] letter,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          window_match,
    output logic                          found,
    output logic                          window_full
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW    = swam_pkg::LETTER_W;
    localparam int QCW   = swam_pkg::QCOUNT_W;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic [LEN_W-1:0] plen_reg, plen_next, seen_reg, seen_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             started_reg, started_next;

    logic [LW-1:0] ring_mem [MAX_PATTERN];
    logic [LW-1:0] ring_q_reg;

    swam_pkg::step_t s1_reg, step_next, s1_step;

    logic             accept;
    logic [LEN_W-1:0] plen_b, seen_b, seen_n, ptr_w;
    logic [PTR_W-1:0] ptr_b, ptr_n;
    logic             started_b, letter_ok, is_pat, is_text, pat_take, win_on;
    logic             remove;

    logic              res_valid;
    swam_pkg::result_t res, head;
    logic [QCW-1:0]    q_count;
    logic [QCW:0]      pending;

    assign accept  = in_valid && in_ready;
    assign pending = (QCW + 1)'(q_count) + (QCW + 1)'(s1_reg.emit) + (QCW + 1)'(res_valid);
    assign in_ready = pending < (QCW + 1)'(swam_pkg::QUEUE_DEPTH);

    always_comb
    begin
        // A first mark acts as a clear before the item itself.
        plen_b    = first ? '0 : plen_reg;
        seen_b    = first ? '0 : seen_reg;
        ptr_b     = first ? '0 : ptr_reg;
        started_b = first ? 1'b0 : started_reg;

        letter_ok = letter < LW'(swam_pkg::ALPHABET);
        is_pat    = letter_ok && op == swam_pkg::OP_PATTERN;
        is_text   = letter_ok && op == swam_pkg::OP_TEXT;
        pat_take  = is_pat && !started_b && plen_b < MAX_LEN;
        win_on    = is_text && plen_b != '0;
        remove    = win_on && seen_b >= plen_b;
        seen_n    = (win_on && !remove) ? seen_b + LEN_W'(1) : seen_b;
        ptr_w     = LEN_W'(ptr_b) + LEN_W'(1);
        ptr_n     = (ptr_w >= plen_b) ? '0 : ptr_w[PTR_W-1:0];

        plen_next    = pat_take ? plen_b + LEN_W'(1) : plen_b;
        seen_next    = seen_n;
        ptr_next     = win_on ? ptr_n : ptr_b;
        started_next = started_b | is_text;

        step_next.first  = first;
        step_next.add    = win_on;
        step_next.remove = remove;
        step_next.pat    = pat_take;
        step_next.emit   = is_text;
        step_next.full   = seen_n >= plen_b;
        step_next.letter = letter;
        step_next.old    = '0;
    end

    // The slot read here is the one about to be overwritten: the oldest letter.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ring_q_reg <= ring_mem[ptr_b];
            if (win_on)
                ring_mem[ptr_b] <= letter;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg    <= '0;
            seen_reg    <= '0;
            ptr_reg     <= '0;
            started_reg <= 1'b0;
            s1_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                plen_reg    <= plen_next;
                seen_reg    <= seen_next;
                ptr_reg     <= ptr_next;
                started_reg <= started_next;
            end
            s1_reg <= accept ? step_next : '0;
        end
    end

    always_comb
    begin
        s1_step     = s1_reg;
        s1_step.old = ring_q_reg;
    end

    swam_counts u_counts
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_step),
        .res_valid (res_valid),
        .res       (res)
    );

    swam_out_queue u_out_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head),
        .count     (q_count)
    );

    assign window_match = head.window_match;
    assign found        = head.found;
    assign window_full  = head.window_full;

endmodule

// ===== rtl/swam_counts.sv =====
// ----------------------------------------------------------------------------
// swam_counts
// Letter count memories, differing-letter count and sticky found flag.
// ----------------------------------------------------------------------------
// Counts are kept as two tallies per letter: entries added to the window, and
// pattern letters plus letters that left the window. A letter's pattern and
// window counts agree exactly when the two tallies are equal modulo 2^COUNT_W.
module swam_counts
(
    input  logic              clk,
    input  logic              rst_n,
    input  swam_pkg::step_t   step,
    output logic              res_valid,
    output swam_pkg::result_t res
);

    localparam int CW = swam_pkg::COUNT_W;
    localparam int AW = swam_pkg::CNT_ADDR_W;
    localparam int NA = swam_pkg::ALPHABET;
    localparam int DW = swam_pkg::DIFF_W;

    logic [CW-1:0] in_mem  [NA];
    logic [CW-1:0] out_mem [NA];

    logic [CW-1:0] in_c_reg, in_o_reg, out_c_reg, out_o_reg;
    swam_pkg::step_t s2_reg;

    logic          in_fwd_v_reg, out_fwd_v_reg;
    logic [AW-1:0] in_fwd_a_reg, out_fwd_a_reg;
    logic [CW-1:0] in_fwd_d_reg, out_fwd_d_reg;
    logic [NA-1:0] in_vld_reg, out_vld_reg, in_vld_next, out_vld_next;
    logic [DW-1:0] diff_reg, diff_next;
    logic          found_reg, found_next;

    logic [AW-1:0] s1_c, s1_o, s2_c, s2_o;
    logic [CW-1:0] in_c, in_o, out_c, out_o, d_c, d_o;
    logic          zero, same, match;
    logic          in_we, out_we;
    logic [AW-1:0] in_wa, out_wa;
    logic [CW-1:0] in_wd, out_wd;
    logic [1:0]    up_cnt, dn_cnt;
    logic          was_c, now_c, was_o, now_o, use_c, use_o;
    logic [DW-1:0] diff_base;

    // Value of an entry as seen by the item in the update stage: a write made
    // at the edge that captured the read wins, and an entry not written since
    // the last clear reads as zero.
    function automatic logic [CW-1:0] pick(
        input logic          clr,
        input logic          fv,
        input logic [AW-1:0] fa,
        input logic [CW-1:0] fd,
        input logic          vld,
        input logic [AW-1:0] a,
        input logic [CW-1:0] q
    );
        logic [CW-1:0] v;
        if (clr)
            v = '0;
        else if (fv && fa == a)
            v = fd;
        else if (vld)
            v = q;
        else
            v = '0;
        return v;
    endfunction

    assign s1_c = step.letter[AW-1:0];
    assign s1_o = step.old[AW-1:0];
    assign s2_c = s2_reg.letter[AW-1:0];
    assign s2_o = s2_reg.old[AW-1:0];

    always_ff @(posedge clk)
    begin
        in_c_reg  <= in_mem[s1_c];
        in_o_reg  <= in_mem[s1_o];
        out_c_reg <= out_mem[s1_c];
        out_o_reg <= out_mem[s1_o];
        if (in_we)
            in_mem[in_wa] <= in_wd;
        if (out_we)
            out_mem[out_wa] <= out_wd;
    end

    always_comb
    begin
        zero  = s2_reg.first;
        in_c  = pick(zero, in_fwd_v_reg, in_fwd_a_reg, in_fwd_d_reg,
                     in_vld_reg[s2_c], s2_c, in_c_reg);
        in_o  = pick(zero, in_fwd_v_reg, in_fwd_a_reg, in_fwd_d_reg,
                     in_vld_reg[s2_o], s2_o, in_o_reg);
        out_c = pick(zero, out_fwd_v_reg, out_fwd_a_reg, out_fwd_d_reg,
                     out_vld_reg[s2_c], s2_c, out_c_reg);
        out_o = pick(zero, out_fwd_v_reg, out_fwd_a_reg, out_fwd_d_reg,
                     out_vld_reg[s2_o], s2_o, out_o_reg);
        d_c   = in_c - out_c;
        d_o   = in_o - out_o;
        same  = s2_reg.old == s2_reg.letter;

        // A letter that leaves and enters at once changes nothing.
        use_c = s2_reg.pat || (s2_reg.add && !(s2_reg.remove && same));
        use_o = s2_reg.remove && !same;
        was_c = d_c != '0;
        now_c = s2_reg.pat ? ((d_c - CW'(1)) != '0) : ((d_c + CW'(1)) != '0);
        was_o = d_o != '0;
        now_o = (d_o - CW'(1)) != '0;

        up_cnt = 2'(use_c && !was_c && now_c) + 2'(use_o && !was_o && now_o);
        dn_cnt = 2'(use_c && was_c && !now_c) + 2'(use_o && was_o && !now_o);

        diff_base  = zero ? '0 : diff_reg;
        diff_next  = diff_base + DW'(up_cnt) - DW'(dn_cnt);
        match      = s2_reg.full && diff_next == '0;
        found_next = (zero ? 1'b0 : found_reg) | (s2_reg.emit && match);

        in_we  = s2_reg.add;
        in_wa  = s2_c;
        in_wd  = in_c + CW'(1);
        out_we = s2_reg.pat || s2_reg.remove;
        out_wa = s2_reg.pat ? s2_c : s2_o;
        out_wd = (s2_reg.pat ? out_c : out_o) + CW'(1);

        in_vld_next  = (zero ? '0 : in_vld_reg)
                     | (in_we ? (NA'(1) << in_wa) : '0);
        out_vld_next = (zero ? '0 : out_vld_reg)
                     | (out_we ? (NA'(1) << out_wa) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg        <= '0;
            in_fwd_v_reg  <= 1'b0;
            out_fwd_v_reg <= 1'b0;
            in_vld_reg    <= '0;
            out_vld_reg   <= '0;
            diff_reg      <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            s2_reg        <= step;
            in_fwd_v_reg  <= in_we;
            out_fwd_v_reg <= out_we;
            in_vld_reg    <= in_vld_next;
            out_vld_reg   <= out_vld_next;
            diff_reg      <= diff_next;
            found_reg     <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_fwd_a_reg  <= in_wa;
        in_fwd_d_reg  <= in_wd;
        out_fwd_a_reg <= out_wa;
        out_fwd_d_reg <= out_wd;
    end

    assign res_valid        = s2_reg.emit;
    assign res.window_match = match;
    assign res.found        = found_next;
    assign res.window_full  = s2_reg.full;

endmodule

// ===== rtl/swam_out_queue.sv =====
// ----------------------------------------------------------------------------
// swam_out_queue
// Small result queue that decouples the count pipeline from the output side.
// ----------------------------------------------------------------------------
module swam_out_queue
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  swam_pkg::result_t                 push_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output swam_pkg::result_t                 head,
    output logic [swam_pkg::QCOUNT_W-1:0]     count
);

    localparam int QD = swam_pkg::QUEUE_DEPTH;
    localparam int PW = swam_pkg::QPTR_W;
    localparam int CW = swam_pkg::QCOUNT_W;

    swam_pkg::result_t entry_reg [QD];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(QD - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(QD - 1)) ? '0 : rd_ptr_reg + PW'(1);
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end

endmodule
